### src/ssc_pkg.sv
// Shared types, widths and helpers for the swept sphere collision pipeline.
`timescale 1ns / 1ps

package ssc_pkg;

    // Default width of one packed coordinate (signed fixed point).
    localparam int COORD_BITS = 21;
    // Width of one packed centre word.
    localparam int WORD_W     = 63;
    // Width of a radius.
    localparam int RAD_W      = 20;
    // Fraction bits of the contact time.
    localparam int T_BITS     = 32;

    // Width of the dot, |s|^2 and radius products, and their sums.
    function automatic int prod_w(input int cb);
        int a;
        int b;
        a = 2 * (cb + 2) + 2;
        b = 2 * RAD_W + 4;
        return (a > b) ? a : b;
    endfunction

    // Sideband that travels with each request down the pipeline.
    typedef struct packed {
        logic [WORD_W-1:0] a_start;
        logic [WORD_W-1:0] a_end;
        logic [WORD_W-1:0] b_start;
        logic [WORD_W-1:0] b_end;
        logic              want;
        logic              hit;
        logic              at_start;
        logic              at_t;
    } side_t;

endpackage

### src/ssc_front.sv
// Relative motion, quadratic terms and hit classification (six stages).
`timescale 1ns / 1ps

module ssc_front #(
    parameter int COORD_BITS = ssc_pkg::COORD_BITS,
    parameter int PW         = ssc_pkg::prod_w(ssc_pkg::COORD_BITS)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           in_valid,
    input  ssc_pkg::side_t                 in_side,
    input  logic [ssc_pkg::RAD_W-1:0]      radius_a,
    input  logic [ssc_pkg::RAD_W-1:0]      radius_b,
    output logic                           out_valid,
    output ssc_pkg::side_t                 out_side,
    output logic [2*PW-1:0]                disc,
    output logic signed [PW-1:0]           dot,
    output logic [PW-1:0]                  e
);

    localparam int CB  = COORD_BITS;
    localparam int SW  = CB + 1;
    localparam int DW  = CB + 2;
    localparam int RRW = ssc_pkg::RAD_W + 1;
    localparam int H   = (PW + 1) / 2;
    localparam int HL  = PW - H;
    localparam int WW  = 2 * PW;

    // Valid chain
    logic [5:0] vld_reg;
    ssc_pkg::side_t side1_reg, side2_reg, side3_reg, side4_reg, side5_reg, side6_reg;

    // Stage 1: relative start offset and relative motion
    logic signed [SW-1:0] s_next [3];
    logic signed [DW-1:0] d_next [3];
    logic signed [SW-1:0] s_reg  [3];
    logic signed [DW-1:0] d_reg  [3];
    logic [RRW-1:0]       rr_reg;

    always_comb
    begin
        logic signed [CB-1:0] as_c, ae_c, bs_c, be_c;
        for (int k = 0; k < 3; k++)
        begin
            as_c = in_side.a_start[k*CB +: CB];
            ae_c = in_side.a_end[k*CB +: CB];
            bs_c = in_side.b_start[k*CB +: CB];
            be_c = in_side.b_end[k*CB +: CB];
            s_next[k] = SW'(as_c) - SW'(bs_c);
            d_next[k] = (DW'(ae_c) - DW'(be_c)) - DW'(s_next[k]);
        end
    end

    // Stage 2: component products
    logic signed [SW+DW-1:0] sd_reg [3];
    logic signed [2*DW-1:0]  dd2_reg [3];
    logic signed [2*SW-1:0]  ss2_reg [3];
    logic [2*RRW-1:0]        rr2_reg;

    // Stage 3: e, dot and c
    logic [PW-1:0]        e3_reg;
    logic signed [PW-1:0] dot3_reg;
    logic signed [PW-1:0] c3_reg;

    // Stage 4: partial products of dot^2 and e*c, and the cheap flags
    logic [PW-1:0]        dot_abs;
    logic [PW-1:0]        c_pos_val;
    logic                 c_pos;
    logic signed [PW+1:0] end_sum;
    logic signed [PW:0]   neg_dot;
    logic [2*H-1:0]       dp00_reg, ep00_reg;
    logic [H+HL-1:0]      dp01_reg, dp10_reg, ep01_reg, ep10_reg;
    logic [2*HL-1:0]      dp11_reg, ep11_reg;
    logic [PW-1:0]        e4_reg;
    logic signed [PW-1:0] dot4_reg;
    logic                 e_zero4_reg, c_pos4_reg, end_ov4_reg, dot_ge4_reg, nd_ge4_reg;

    assign dot_abs   = dot3_reg[PW-1] ? PW'(-dot3_reg) : PW'(dot3_reg);
    assign c_pos     = !c3_reg[PW-1] && (c3_reg != '0);
    assign c_pos_val = c_pos ? PW'(c3_reg) : '0;
    assign end_sum   = $signed((PW+2)'(e3_reg)) + ((PW+2)'(dot3_reg) <<< 1)
                       + (PW+2)'(c3_reg);
    assign neg_dot   = -((PW+1)'(dot3_reg));

    // Stage 5: full dot^2 and e*c
    logic [WW-1:0]        dd5_reg, ec5_reg;
    logic [PW-1:0]        e5_reg;
    logic signed [PW-1:0] dot5_reg;
    logic                 e_zero5_reg, c_pos5_reg, end_ov5_reg, dot_ge5_reg, nd_ge5_reg;

    // Stage 6: discriminant and classification
    logic                 disc_neg;
    ssc_pkg::side_t       side6_next;
    logic [2*PW-1:0]      disc_reg;
    logic signed [PW-1:0] dot6_reg;
    logic [PW-1:0]        e6_reg;

    always_comb
    begin
        side6_next          = side5_reg;
        disc_neg            = dd5_reg < ec5_reg;
        side6_next.hit      = !e_zero5_reg && !(c_pos5_reg && disc_neg)
                              && (!c_pos5_reg || end_ov5_reg
                                  || (!dot_ge5_reg && !nd_ge5_reg));
        side6_next.at_start = side6_next.hit && !c_pos5_reg;
        side6_next.at_t     = side6_next.hit && c_pos5_reg;
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[4:0], in_valid};
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side1_reg <= in_side;
            for (int k = 0; k < 3; k++)
            begin
                s_reg[k] <= s_next[k];
                d_reg[k] <= d_next[k];
            end
            rr_reg <= RRW'(radius_a) + RRW'(radius_b);

            side2_reg <= side1_reg;
            for (int k = 0; k < 3; k++)
            begin
                sd_reg[k]  <= (SW+DW)'(s_reg[k]) * (SW+DW)'(d_reg[k]);
                dd2_reg[k] <= (2*DW)'(d_reg[k]) * (2*DW)'(d_reg[k]);
                ss2_reg[k] <= (2*SW)'(s_reg[k]) * (2*SW)'(s_reg[k]);
            end
            rr2_reg <= (2*RRW)'(rr_reg) * (2*RRW)'(rr_reg);

            side3_reg <= side2_reg;
            e3_reg    <= PW'(PW'(dd2_reg[0]) + PW'(dd2_reg[1]) + PW'(dd2_reg[2]));
            dot3_reg  <= PW'(sd_reg[0]) + PW'(sd_reg[1]) + PW'(sd_reg[2]);
            c3_reg    <= PW'(ss2_reg[0]) + PW'(ss2_reg[1]) + PW'(ss2_reg[2])
                         - $signed(PW'(rr2_reg));

            side4_reg   <= side3_reg;
            dp00_reg    <= (2*H)'(dot_abs[H-1:0]) * (2*H)'(dot_abs[H-1:0]);
            dp01_reg    <= (H+HL)'(dot_abs[H-1:0]) * (H+HL)'(dot_abs[PW-1:H]);
            dp10_reg    <= (H+HL)'(dot_abs[PW-1:H]) * (H+HL)'(dot_abs[H-1:0]);
            dp11_reg    <= (2*HL)'(dot_abs[PW-1:H]) * (2*HL)'(dot_abs[PW-1:H]);
            ep00_reg    <= (2*H)'(e3_reg[H-1:0]) * (2*H)'(c_pos_val[H-1:0]);
            ep01_reg    <= (H+HL)'(e3_reg[H-1:0]) * (H+HL)'(c_pos_val[PW-1:H]);
            ep10_reg    <= (H+HL)'(e3_reg[PW-1:H]) * (H+HL)'(c_pos_val[H-1:0]);
            ep11_reg    <= (2*HL)'(e3_reg[PW-1:H]) * (2*HL)'(c_pos_val[PW-1:H]);
            e4_reg      <= e3_reg;
            dot4_reg    <= dot3_reg;
            e_zero4_reg <= (e3_reg == '0);
            c_pos4_reg  <= c_pos;
            end_ov4_reg <= end_sum[PW+1] || (end_sum == '0);
            dot_ge4_reg <= !dot3_reg[PW-1];
            nd_ge4_reg  <= neg_dot >= $signed({1'b0, e3_reg});

            side5_reg   <= side4_reg;
            dd5_reg     <= WW'(dp00_reg) + (WW'(dp01_reg) << H) + (WW'(dp10_reg) << H)
                           + (WW'(dp11_reg) << (2*H));
            ec5_reg     <= WW'(ep00_reg) + (WW'(ep01_reg) << H) + (WW'(ep10_reg) << H)
                           + (WW'(ep11_reg) << (2*H));
            e5_reg      <= e4_reg;
            dot5_reg    <= dot4_reg;
            e_zero5_reg <= e_zero4_reg;
            c_pos5_reg  <= c_pos4_reg;
            end_ov5_reg <= end_ov4_reg;
            dot_ge5_reg <= dot_ge4_reg;
            nd_ge5_reg  <= nd_ge4_reg;

            side6_reg <= side6_next;
            disc_reg  <= dd5_reg - ec5_reg;
            dot6_reg  <= dot5_reg;
            e6_reg    <= e5_reg;
        end
    end

    assign out_valid = vld_reg[5];
    assign out_side  = side6_reg;
    assign disc      = disc_reg;
    assign dot       = dot6_reg;
    assign e         = e6_reg;

endmodule

### src/ssc_sqrt.sv
// Pipelined integer square root of the discriminant, one root bit a stage.
`timescale 1ns / 1ps

module ssc_sqrt #(
    parameter int PW = ssc_pkg::prod_w(ssc_pkg::COORD_BITS)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  ssc_pkg::side_t       in_side,
    input  logic [2*PW-1:0]      disc,
    input  logic signed [PW-1:0] in_dot,
    input  logic [PW-1:0]        in_e,
    output logic                 out_valid,
    output ssc_pkg::side_t       out_side,
    output logic [PW-1:0]        root,
    output logic signed [PW-1:0] out_dot,
    output logic [PW-1:0]        out_e
);

    localparam int RW = PW + 3;

    logic                 vld_reg  [PW];
    ssc_pkg::side_t       side_reg [PW];
    logic [2*PW-1:0]      v_reg    [PW];
    logic [RW-1:0]        r_reg    [PW];
    logic [PW-1:0]        q_reg    [PW];
    logic signed [PW-1:0] dot_reg  [PW];
    logic [PW-1:0]        e_reg    [PW];

    for (genvar i = 0; i < PW; i++)
    begin : g_step
        logic                 vld_in;
        ssc_pkg::side_t       side_in;
        logic [2*PW-1:0]      v_in;
        logic [RW-1:0]        r_in;
        logic [PW-1:0]        q_in;
        logic signed [PW-1:0] dot_in;
        logic [PW-1:0]        e_in;
        logic [RW-1:0]        r_sh;
        logic [RW-1:0]        trial;
        logic                 ge;

        if (i == 0)
        begin : g_first
            assign vld_in  = in_valid;
            assign side_in = in_side;
            assign v_in    = disc;
            assign r_in    = '0;
            assign q_in    = '0;
            assign dot_in  = in_dot;
            assign e_in    = in_e;
        end
        else
        begin : g_rest
            assign vld_in  = vld_reg[i-1];
            assign side_in = side_reg[i-1];
            assign v_in    = v_reg[i-1];
            assign r_in    = r_reg[i-1];
            assign q_in    = q_reg[i-1];
            assign dot_in  = dot_reg[i-1];
            assign e_in    = e_reg[i-1];
        end

        // Bring down the next two radicand bits and try the next root bit
        assign r_sh  = {r_in[RW-3:0], v_in[2*PW-1 -: 2]};
        assign trial = {1'b0, q_in, 2'b01};
        assign ge    = r_sh >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[i] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[i] <= side_in;
                v_reg[i]    <= {v_in[2*PW-3:0], 2'b00};
                r_reg[i]    <= ge ? (r_sh - trial) : r_sh;
                q_reg[i]    <= {q_in[PW-2:0], ge};
                dot_reg[i]  <= dot_in;
                e_reg[i]    <= e_in;
            end
        end
    end

    assign out_valid = vld_reg[PW-1];
    assign out_side  = side_reg[PW-1];
    assign root      = q_reg[PW-1];
    assign out_dot   = dot_reg[PW-1];
    assign out_e     = e_reg[PW-1];

endmodule

### src/ssc_div.sv
// Contact time: clamp of -dot - root to [0,e], then a restoring divide by e.
`timescale 1ns / 1ps

module ssc_div #(
    parameter int PW = ssc_pkg::prod_w(ssc_pkg::COORD_BITS)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  ssc_pkg::side_t               in_side,
    input  logic [PW-1:0]                root,
    input  logic signed [PW-1:0]         dot,
    input  logic [PW-1:0]                e,
    output logic                         out_valid,
    output ssc_pkg::side_t               out_side,
    output logic [ssc_pkg::T_BITS:0]     tq
);

    localparam int TB = ssc_pkg::T_BITS;

    // Numerator stage
    logic signed [PW+1:0] num;
    logic [PW-1:0]        num_c;
    logic                 n_vld_reg;
    ssc_pkg::side_t       n_side_reg;
    logic [PW-1:0]        n_r_reg;
    logic [PW-1:0]        n_e_reg;
    logic                 n_full_reg;

    always_comb
    begin
        num = -((PW+2)'(dot)) - $signed({2'b00, root});
        if (num[PW+1])
        begin
            num_c = '0;
        end
        else if (num > $signed({2'b00, e}))
        begin
            num_c = e;
        end
        else
        begin
            num_c = num[PW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            n_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_side_reg <= in_side;
            n_r_reg    <= num_c;
            n_e_reg    <= e;
            n_full_reg <= (num_c == e);
        end
    end

    // Quotient stages, one bit each
    logic           vld_reg  [TB];
    ssc_pkg::side_t side_reg [TB];
    logic [PW-1:0]  r_reg    [TB];
    logic [TB-1:0]  q_reg    [TB];
    logic [PW-1:0]  e_reg    [TB];
    logic           full_reg [TB];

    for (genvar i = 0; i < TB; i++)
    begin : g_step
        logic           vld_in;
        ssc_pkg::side_t side_in;
        logic [PW-1:0]  r_in;
        logic [TB-1:0]  q_in;
        logic [PW-1:0]  e_in;
        logic           full_in;
        logic [PW:0]    r_sh;
        logic [PW:0]    r_sub;
        logic           ge;

        if (i == 0)
        begin : g_first
            assign vld_in  = n_vld_reg;
            assign side_in = n_side_reg;
            assign r_in    = n_r_reg;
            assign q_in    = '0;
            assign e_in    = n_e_reg;
            assign full_in = n_full_reg;
        end
        else
        begin : g_rest
            assign vld_in  = vld_reg[i-1];
            assign side_in = side_reg[i-1];
            assign r_in    = r_reg[i-1];
            assign q_in    = q_reg[i-1];
            assign e_in    = e_reg[i-1];
            assign full_in = full_reg[i-1];
        end

        assign r_sh  = {r_in, 1'b0};
        assign ge    = r_sh >= {1'b0, e_in};
        assign r_sub = r_sh - {1'b0, e_in};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[i] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[i] <= side_in;
                r_reg[i]    <= ge ? r_sub[PW-1:0] : r_sh[PW-1:0];
                q_reg[i]    <= {q_in[TB-2:0], ge};
                e_reg[i]    <= e_in;
                full_reg[i] <= full_in;
            end
        end
    end

    assign out_valid = vld_reg[TB-1];
    assign out_side  = side_reg[TB-1];
    assign tq        = full_reg[TB-1] ? {1'b1, {TB{1'b0}}} : {1'b0, q_reg[TB-1]};

endmodule

### src/ssc_lerp.sv
// Contact centres by interpolation, rounding, saturation and output register.
`timescale 1ns / 1ps

module ssc_lerp #(
    parameter int COORD_BITS = ssc_pkg::COORD_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  ssc_pkg::side_t                in_side,
    input  logic [ssc_pkg::T_BITS:0]      tq,
    output logic                          out_valid,
    output logic                          out_hit,
    output logic [ssc_pkg::WORD_W-1:0]    a_contact,
    output logic [ssc_pkg::WORD_W-1:0]    b_contact
);

    localparam int CB   = COORD_BITS;
    localparam int SW   = CB + 1;
    localparam int TB   = ssc_pkg::T_BITS;
    localparam int PRW  = TB + 2 + SW;
    localparam int QW   = PRW + 1 - TB;
    localparam int XW   = QW + 1;
    localparam int MAXI = 2 ** (CB - 1) - 1;
    localparam int MINI = -(2 ** (CB - 1));

    // Coordinates 0..2 belong to sphere A, 3..5 to sphere B
    function automatic logic signed [CB-1:0] start_c(input ssc_pkg::side_t sd, input int j);
        return (j < 3) ? sd.a_start[j*CB +: CB] : sd.b_start[(j-3)*CB +: CB];
    endfunction

    function automatic logic signed [CB-1:0] end_c(input ssc_pkg::side_t sd, input int j);
        return (j < 3) ? sd.a_end[j*CB +: CB] : sd.b_end[(j-3)*CB +: CB];
    endfunction

    logic [2:0]            vld_reg;
    ssc_pkg::side_t        side1_reg, side2_reg;
    logic signed [PRW-1:0] prod_reg [6];
    logic [QW-1:0]         q_reg    [6];
    logic                  neg_reg  [6];
    logic                  full1_reg;
    logic                  hit3_reg;
    logic [ssc_pkg::WORD_W-1:0] a3_reg, b3_reg;

    // Stage 1: t times the travel of each coordinate
    logic signed [SW-1:0]  diff [6];
    logic signed [PRW-1:0] prod_next [6];

    always_comb
    begin
        for (int j = 0; j < 6; j++)
        begin
            diff[j]      = SW'(end_c(in_side, j)) - SW'(start_c(in_side, j));
            prod_next[j] = $signed(PRW'({1'b0, tq})) * PRW'(diff[j]);
        end
    end

    // Stage 2: magnitude rounded half away from zero
    logic [PRW-1:0] mag  [6];
    logic [PRW:0]   rnd  [6];

    always_comb
    begin
        for (int j = 0; j < 6; j++)
        begin
            mag[j] = prod_reg[j][PRW-1] ? PRW'(-prod_reg[j]) : PRW'(prod_reg[j]);
            rnd[j] = (PRW+1)'(mag[j]) + ((PRW+1)'(1) << (TB - 1));
        end
    end

    // Stage 3: offset from the start, saturate, choose and pack
    logic signed [XW-1:0]  pos  [6];
    logic signed [CB-1:0]  sat  [6];
    logic [ssc_pkg::WORD_W-1:0] a_next, b_next;

    always_comb
    begin
        a_next = '0;
        b_next = '0;
        for (int j = 0; j < 6; j++)
        begin
            pos[j] = neg_reg[j] ? XW'(start_c(side2_reg, j)) - $signed({1'b0, q_reg[j]})
                                : XW'(start_c(side2_reg, j)) + $signed({1'b0, q_reg[j]});
            if (pos[j] < $signed(XW'(MINI)))
            begin
                sat[j] = CB'(MINI);
            end
            else if (pos[j] > $signed(XW'(MAXI)))
            begin
                sat[j] = CB'(MAXI);
            end
            else
            begin
                sat[j] = pos[j][CB-1:0];
            end
            if (side2_reg.want && side2_reg.at_t)
            begin
                sat[j] = sat[j];
            end
            else if (side2_reg.want && side2_reg.at_start)
            begin
                sat[j] = start_c(side2_reg, j);
            end
            else
            begin
                sat[j] = end_c(side2_reg, j);
            end
        end
        for (int k = 0; k < 3; k++)
        begin
            a_next[k*CB +: CB] = sat[k];
            b_next[k*CB +: CB] = sat[k+3];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side1_reg <= in_side;
            full1_reg <= tq[TB];
            for (int j = 0; j < 6; j++)
            begin
                prod_reg[j] <= prod_next[j];
            end
            side2_reg <= side1_reg;
            for (int j = 0; j < 6; j++)
            begin
                q_reg[j]   <= rnd[j][PRW:TB];
                neg_reg[j] <= prod_reg[j][PRW-1];
            end
            hit3_reg <= side2_reg.hit;
            a3_reg   <= a_next;
            b3_reg   <= b_next;
        end
    end

    assign out_valid = vld_reg[2];
    assign out_hit   = hit3_reg;
    assign a_contact = a3_reg;
    assign b_contact = b3_reg;

    // A hit is always exactly one of the two contact kinds
    assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[1] |-> (side2_reg.hit == (side2_reg.at_start || side2_reg.at_t)))
        else $error("hit does not match contact kind");

    assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[1] |-> !(side2_reg.at_start && side2_reg.at_t))
        else $error("both contact kinds set");

    // A full time step carries no fraction bits
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && tq[TB]) |-> (tq[TB-1:0] == '0))
        else $error("contact time above one");

    // With no hit the result leaves with its hit flag clear
    assert property (@(posedge clk) disable iff (!rst_n)
        (en && vld_reg[1] && !side2_reg.hit) |=> (out_valid && !out_hit))
        else $error("miss lost its flag at the output");

    // Full step flag follows the request into the product stage
    assert property (@(posedge clk) disable iff (!rst_n)
        (en && in_valid) |=> (full1_reg == $past(tq[TB])))
        else $error("time flag not captured");

endmodule

### src/swept_sphere_collision_test.sv
// Top level of the swept sphere collision test pipeline.
//
//  channel  dir  fields (low bit first)
//  s_*      in   tdata: a_start[62:0] a_end[125:63] b_start[188:126]
//                       b_end[251:189] radius_a[271:252] radius_b[291:272]
//                tuser: want_contact
//  m_*      out  tdata: a_contact[62:0] b_contact[125:63]; tuser: hit
//
// One request enters per cycle while the output is not stalled. The square root
// and the divider resolve one bit a stage: P root bits, P being the product
// width (48 at 21-bit coordinates), and the T = 32 time fraction bits.
// Reset clears the valid bits only. A stalled output freezes every stage
// together; the output register holds its result until taken.
`timescale 1ns / 1ps

module swept_sphere_collision_test #(
    parameter int COORD_BITS = ssc_pkg::COORD_BITS
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [295:0] s_tdata,   // a_start, a_end, b_start, b_end, radius_a, radius_b
    input  logic [0:0]   s_tuser,   // want_contact
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // a_contact, b_contact
    output logic [0:0]   m_tuser    // hit
);

    localparam int PW = ssc_pkg::prod_w(COORD_BITS);
    localparam int WW = ssc_pkg::WORD_W;
    localparam int RW = ssc_pkg::RAD_W;

    logic en;

    ssc_pkg::side_t in_side;
    ssc_pkg::side_t f_side, q_side, d_side;
    logic           f_valid, q_valid, d_valid;
    logic [2*PW-1:0]      disc;
    logic signed [PW-1:0] f_dot, q_dot;
    logic [PW-1:0]        f_e, q_e, root;
    logic [ssc_pkg::T_BITS:0] tq;
    logic                 hit;
    logic [WW-1:0]        a_contact, b_contact;

    // Whole pipeline advances whenever the output register can take a result
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    always_comb
    begin
        in_side          = '0;
        in_side.a_start  = s_tdata[WW-1:0];
        in_side.a_end    = s_tdata[2*WW-1:WW];
        in_side.b_start  = s_tdata[3*WW-1:2*WW];
        in_side.b_end    = s_tdata[4*WW-1:3*WW];
        in_side.want     = s_tuser[0];
    end

    ssc_front #(.COORD_BITS(COORD_BITS), .PW(PW)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_side   (in_side),
        .radius_a  (s_tdata[4*WW+RW-1:4*WW]),
        .radius_b  (s_tdata[4*WW+2*RW-1:4*WW+RW]),
        .out_valid (f_valid),
        .out_side  (f_side),
        .disc      (disc),
        .dot       (f_dot),
        .e         (f_e)
    );

    ssc_sqrt #(.PW(PW)) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f_valid),
        .in_side   (f_side),
        .disc      (disc),
        .in_dot    (f_dot),
        .in_e      (f_e),
        .out_valid (q_valid),
        .out_side  (q_side),
        .root      (root),
        .out_dot   (q_dot),
        .out_e     (q_e)
    );

    ssc_div #(.PW(PW)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (q_valid),
        .in_side   (q_side),
        .root      (root),
        .dot       (q_dot),
        .e         (q_e),
        .out_valid (d_valid),
        .out_side  (d_side),
        .tq        (tq)
    );

    ssc_lerp #(.COORD_BITS(COORD_BITS)) u_lerp (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (d_valid),
        .in_side   (d_side),
        .tq        (tq),
        .out_valid (m_tvalid),
        .out_hit   (hit),
        .a_contact (a_contact),
        .b_contact (b_contact)
    );

    assign m_tdata = {2'b00, b_contact, a_contact};
    assign m_tuser = hit;

endmodule

### bench/tb_top.sv
// Self-checking bench for the swept sphere collision test pipeline.
`timescale 1ns / 1ps

module tb_top;

    localparam int CB       = ssc_pkg::COORD_BITS;
    localparam int WORD_W   = ssc_pkg::WORD_W;
    localparam int RAD_W    = ssc_pkg::RAD_W;
    localparam int T_BITS   = ssc_pkg::T_BITS;
    localparam int N_RANDOM = 1540;
    localparam int DRAIN    = 200;

    typedef struct packed {
        logic [WORD_W-1:0] a_s;
        logic [WORD_W-1:0] a_e;
        logic [WORD_W-1:0] b_s;
        logic [WORD_W-1:0] b_e;
        logic [RAD_W-1:0]  ra;
        logic [RAD_W-1:0]  rb;
        logic              want;
    } pair_t;

    typedef struct packed {
        logic              hit;
        logic [WORD_W-1:0] a_c;
        logic [WORD_W-1:0] b_c;
    } contact_t;

    typedef struct {
        pair_t    req;
        logic     typed;
        contact_t res;
    } row_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [295:0] s_tdata;
    logic [0:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;
    logic [0:0]   m_tuser;

    contact_t pending_contacts[$];
    row_t     rows[$];
    int       n_errors;
    int       send_idle_pct;
    int       recv_stall_pct;

    swept_sphere_collision_test i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Pack three signed coordinates into a centre word
    function automatic logic [WORD_W-1:0] centre(input longint x, input longint y,
                                                 input longint z);
        logic [WORD_W-1:0] w;
        w = '0;
        w[0 +: CB]    = x[CB-1:0];
        w[CB +: CB]   = y[CB-1:0];
        w[2*CB +: CB] = z[CB-1:0];
        return w;
    endfunction

    function automatic longint coord_of(input logic [WORD_W-1:0] w, input int k);
        logic signed [CB-1:0] v;
        v = w[k*CB +: CB];
        return longint'(v);
    endfunction

    // Interpolate one coordinate at time tq, rounded half away, saturated
    function automatic longint lerp_coord(input longint st, input longint en,
                                          input longint tq);
        longint prod;
        longint mag;
        longint q;
        longint r;
        longint lim;
        lim  = longint'(1) <<< (CB - 1);
        prod = tq * (en - st);
        mag  = (prod < 0) ? -prod : prod;
        q    = (mag + (longint'(1) <<< (T_BITS - 1))) >>> T_BITS;
        r    = (prod < 0) ? st - q : st + q;
        if (r < -lim)
            r = -lim;
        if (r > lim - 1)
            r = lim - 1;
        return r;
    endfunction

    // Expected hit flag and contact centres for one pair
    function automatic contact_t sweep_contact(input pair_t p);
        contact_t          res;
        longint            as_[3];
        longint            ae_[3];
        longint            bs_[3];
        longint            be_[3];
        longint            ac_[3];
        longint            bc_[3];
        logic signed [127:0] s;
        logic signed [127:0] d;
        logic signed [127:0] e;
        logic signed [127:0] dotp;
        logic signed [127:0] ss;
        logic signed [127:0] rr;
        logic signed [127:0] c;
        logic signed [127:0] dd;
        logic signed [127:0] ec;
        logic signed [127:0] disc;
        logic signed [127:0] lo;
        logic signed [127:0] hi;
        logic signed [127:0] mid;
        logic signed [127:0] num;
        longint            tq;
        int                hit;
        int                at_mode; // 0 ends, 1 starts, 2 at t
        e    = 0;
        dotp = 0;
        ss   = 0;
        hit  = 0;
        at_mode = 0;
        for (int k = 0; k < 3; k++)
        begin
            as_[k] = coord_of(p.a_s, k);
            ae_[k] = coord_of(p.a_e, k);
            bs_[k] = coord_of(p.b_s, k);
            be_[k] = coord_of(p.b_e, k);
            s = as_[k] - bs_[k];
            d = (ae_[k] - be_[k]) - s;
            e    = e + d * d;
            dotp = dotp + s * d;
            ss   = ss + s * s;
        end
        rr = 128'(p.ra) + 128'(p.rb);
        c  = ss - rr * rr;
        dd = dotp * dotp;
        ec = (c > 0) ? e * c : 0;

        // decision order: stationary, miss, start overlap, end overlap, direction
        if (e == 0)
            hit = 0;
        else if (c > 0 && dd < ec)
            hit = 0;
        else if (c <= 0)
        begin
            hit = 1;
            at_mode = 1;
        end
        else if (e + 2 * dotp + c <= 0)
        begin
            hit = 1;
            at_mode = 2;
        end
        else if (dotp >= 0)
            hit = 0;
        else if (-dotp >= e)
            hit = 0;
        else
        begin
            hit = 1;
            at_mode = 2;
        end

        for (int k = 0; k < 3; k++)
        begin
            ac_[k] = ae_[k];
            bc_[k] = be_[k];
        end
        if (hit == 1 && p.want && at_mode == 1)
        begin
            for (int k = 0; k < 3; k++)
            begin
                ac_[k] = as_[k];
                bc_[k] = bs_[k];
            end
        end
        else if (hit == 1 && p.want && at_mode == 2)
        begin
            // floor square root of the discriminant
            disc = dd - ec;
            lo   = 0;
            hi   = 128'sd1 <<< 47;
            while (lo < hi)
            begin
                mid = lo + (hi - lo + 1) / 2;
                if (mid * mid <= disc)
                    lo = mid;
                else
                    hi = mid - 1;
            end
            num = -dotp - lo;
            if (num < 0)
                num = 0;
            if (num > e)
                num = e;
            if (num == e)
                tq = longint'(1) <<< T_BITS;
            else
                tq = longint'((num <<< T_BITS) / e);
            for (int k = 0; k < 3; k++)
            begin
                ac_[k] = lerp_coord(as_[k], ae_[k], tq);
                bc_[k] = lerp_coord(bs_[k], be_[k], tq);
            end
        end
        res.hit = (hit == 1);
        res.a_c = centre(ac_[0], ac_[1], ac_[2]);
        res.b_c = centre(bc_[0], bc_[1], bc_[2]);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                   input logic [WORD_W-1:0] want_v);
        $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want_v);
        n_errors++;
    endtask

    function automatic longint near(input longint c0, input int span);
        return c0 + $signed($urandom_range(2 * span)) - span;
    endfunction

    // Random pair: mostly spheres near a common centre, the rest raw bits
    function automatic pair_t random_pair();
        pair_t        p;
        logic [319:0] raw;
        longint       cx;
        longint       cy;
        longint       cz;
        int           span;
        if ($urandom_range(99) < 30)
        begin
            raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom, $urandom};
            p = raw[$bits(pair_t)-1:0];
            return p;
        end
        span = ($urandom_range(3) == 0) ? 200000 : 8000;
        cx = $signed($urandom_range(1600000)) - 800000;
        cy = $signed($urandom_range(1600000)) - 800000;
        cz = $signed($urandom_range(1600000)) - 800000;
        p.a_s  = centre(near(cx, span), near(cy, span), near(cz, span));
        p.a_e  = centre(near(cx, span), near(cy, span), near(cz, span));
        p.b_s  = centre(near(cx, span), near(cy, span), near(cz, span));
        p.b_e  = centre(near(cx, span), near(cy, span), near(cz, span));
        p.ra   = ($urandom_range(9) == 0) ? RAD_W'($urandom) : RAD_W'($urandom_range(span));
        p.rb   = ($urandom_range(9) == 0) ? RAD_W'($urandom) : RAD_W'($urandom_range(span));
        p.want = ($urandom_range(3) != 0);
        return p;
    endfunction

    function automatic void add_row(input pair_t p, input logic typed, input contact_t r);
        row_t row;
        row.req   = p;
        row.typed = typed;
        row.res   = r;
        rows.push_back(row);
    endfunction

    function automatic pair_t mk(input logic [WORD_W-1:0] as_w, input logic [WORD_W-1:0] ae_w,
                                 input logic [WORD_W-1:0] bs_w, input logic [WORD_W-1:0] be_w,
                                 input int ra, input int rb, input logic want);
        pair_t p;
        p.a_s = as_w;
        p.a_e = ae_w;
        p.b_s = bs_w;
        p.b_e = be_w;
        p.ra  = RAD_W'(ra);
        p.rb  = RAD_W'(rb);
        p.want = want;
        return p;
    endfunction

    // Phase of idling follows the request count
    function automatic void set_phase(input int idx);
        case ((idx / 100) % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
            default: begin send_idle_pct = 34; recv_stall_pct = 34; end
        endcase
    endfunction

    // Sender
    initial
    begin
        logic [WORD_W-1:0] z;
        logic [WORD_W-1:0] mx;
        logic [WORD_W-1:0] mn;
        logic [WORD_W-1:0] ones;
        pair_t             p;
        row_t              row;
        int                total;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        n_errors = 0;
        set_phase(0);

        z    = centre(0, 0, 0);
        mx   = centre(1048575, 1048575, 1048575);
        mn   = centre(-1048576, -1048576, -1048576);
        ones = '1;
        // stationary pairs: no hit, ends pass through
        add_row(mk(z, z, z, z, 0, 0, 1), 1, '{1'b0, z, z});
        add_row(mk(mx, mx, mn, mn, 1048575, 1048575, 1), 1, '{1'b0, mx, mn});
        add_row(mk(ones, ones, ones, ones, 1048575, 1048575, 1), 1, '{1'b0, ones, ones});
        // overlap at the start: contacts are the starts when wanted, else the ends
        add_row(mk(z, centre(5000, 0, 0), centre(100, 0, 0), centre(100, 0, 0), 1024, 1024, 1),
                1, '{1'b1, z, centre(100, 0, 0)});
        add_row(mk(z, centre(5000, 0, 0), centre(100, 0, 0), centre(100, 0, 0), 1024, 1024, 0),
                1, '{1'b1, centre(5000, 0, 0), centre(100, 0, 0)});
        // head-on sweep through, with and without contact
        add_row(mk(centre(-10000, 0, 0), centre(10000, 0, 0), z, z, 1024, 1024, 1), 0, '0);
        add_row(mk(centre(-10000, 0, 0), centre(10000, 0, 0), z, z, 1024, 1024, 0), 0, '0);
        // parallel offset miss, moving apart, stopping short
        add_row(mk(centre(-10000, 0, 0), centre(10000, 0, 0), centre(0, 100000, 0),
                   centre(0, 100000, 0), 1024, 1024, 1), 0, '0);
        add_row(mk(centre(-5000, 0, 0), centre(-20000, 0, 0), z, z, 1024, 1024, 1), 0, '0);
        add_row(mk(centre(-20000, 0, 0), centre(-10000, 0, 0), z, z, 1024, 1024, 1), 0, '0);
        // overlap only at the end
        add_row(mk(centre(-5000, 0, 0), centre(0, 0, 0), z, z, 1024, 1024, 1), 0, '0);
        // both spheres moving, mostly from opposite corners, radii up to the largest
        add_row(mk(mn, mx, mx, mn, 1048575, 1048575, 1), 0, '0);
        add_row(mk(mn, mx, centre(1048575, -1048576, 0), centre(-1048576, 1048575, 0),
                   7, 9, 1), 0, '0);
        add_row(mk(centre(-1048576, 0, 1048575), centre(1048575, 3, -1048576), z,
                   centre(1, 1, 1), 0, 1, 1), 0, '0);
        add_row(mk(ones, z, z, ones, 1048575, 0, 1), 0, '0);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        total = rows.size() + N_RANDOM;
        for (int i = 0; i < total; i++)
        begin
            set_phase(i);
            if (i < rows.size())
                row = rows[i];
            else
            begin
                row.req   = random_pair();
                row.typed = 0;
            end
            p = row.req;
            pending_contacts.push_back(row.typed ? row.res : sweep_contact(p));
            while ($urandom_range(99) < send_idle_pct)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= {4'b0, p.rb, p.ra, p.b_e, p.b_s, p.a_e, p.a_s};
            s_tuser  <= p.want;
            @(posedge clk);
            while (!s_tready)
                @(posedge clk);
        end
        s_tvalid <= 1'b0;

        while (pending_contacts.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        if (n_errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Receiver: check each returned request, then choose next ready
    initial
    begin
        contact_t exp_c;
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                if (pending_contacts.size() == 0)
                begin
                    report_mismatch("unexpected result", m_tdata[62:0], '0);
                end
                else
                begin
                    exp_c = pending_contacts.pop_front();
                    if (m_tuser[0] !== exp_c.hit)
                        report_mismatch("hit", WORD_W'(m_tuser[0]), WORD_W'(exp_c.hit));
                    if (m_tdata[62:0] !== exp_c.a_c)
                        report_mismatch("a_contact", m_tdata[62:0], exp_c.a_c);
                    if (m_tdata[125:63] !== exp_c.b_c)
                        report_mismatch("b_contact", m_tdata[125:63], exp_c.b_c);
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog
    initial
    begin
        #5ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
